>>> rtl/core/dspg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the dual stepper pulse generator.
// No dependencies; all other files of the block but dspg_queue refer to it by scoped names.
package dspg_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DELAY_W    = 32;
	localparam int MS_CODE_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY_FULL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_LIMIT = 2'd2;

	localparam logic [CFG_DATA_W-1:0] MIN_DELAY_FULL_RST = 32'd300000;
	localparam logic [CFG_DATA_W-1:0] MAX_DELAY_RST      = 32'd200000000;
	localparam logic [CFG_DATA_W-1:0] WATCHDOG_LIMIT_RST = 32'(200 * 1000 * 1000 / 2);

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_OFF,
		KIND_BADMS,
		KIND_RUN
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [MS_CODE_W-1:0] ms_code;
		logic                 dir_l;
		logic                 dir_r;
	} cmd_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] min_delay_full;
		logic [CFG_DATA_W-1:0] max_delay;
		logic [CFG_DATA_W-1:0] watchdog_limit;
	} cfg_t;

endpackage

>>> rtl/core/dspg_front.sv
`timescale 1ns / 1ps
// Front part: classify an incoming item and clamp the frame delays.
// Depends on dspg_pkg for cmd_t and cfg_t.
module dspg_front #(
	parameter int TIMER_WIDTH = 32
) (
	input  logic                          mode,
	input  logic [7:0]                    enable_cmd,
	input  logic [7:0]                    microstep,
	input  logic [7:0]                    dir_left_cmd,
	input  logic [7:0]                    dir_right_cmd,
	input  logic [dspg_pkg::DELAY_W-1:0]  delay_left,
	input  logic [dspg_pkg::DELAY_W-1:0]  delay_right,
	input  dspg_pkg::cfg_t                cfg,
	output dspg_pkg::cmd_t                cmd,
	output logic [TIMER_WIDTH-1:0]        period_l,
	output logic [TIMER_WIDTH-1:0]        period_r
);

	localparam int XW = (TIMER_WIDTH > dspg_pkg::DELAY_W) ? TIMER_WIDTH : dspg_pkg::DELAY_W;

	logic [dspg_pkg::MS_CODE_W-1:0] code;
	logic [2:0]                     shamt;
	logic                           ms_ok;
	logic [dspg_pkg::DELAY_W-1:0]   floor_v;

	function automatic logic [TIMER_WIDTH-1:0] clamp(
		input logic [dspg_pkg::DELAY_W-1:0] d,
		input logic [dspg_pkg::DELAY_W-1:0] fl,
		input logic [dspg_pkg::DELAY_W-1:0] mx
	);
		logic [dspg_pkg::DELAY_W-1:0] v;
		logic [XW-1:0]                vx;
		logic [XW-1:0]                tmax;
		v = d;
		if (v != '0 && v < fl) v = fl;
		if (v > mx) v = mx;
		vx   = XW'(v);
		tmax = XW'({TIMER_WIDTH{1'b1}});
		if (vx > tmax) vx = tmax;
		return TIMER_WIDTH'(vx);
	endfunction

	always_comb begin
		code  = 3'd0;
		shamt = 3'd0;
		ms_ok = 1'b1;
		case (microstep)
			8'd1: begin
				code  = 3'd0;
				shamt = 3'd0;
			end
			8'd2: begin
				code  = 3'd1;
				shamt = 3'd1;
			end
			8'd4: begin
				code  = 3'd2;
				shamt = 3'd2;
			end
			8'd8: begin
				code  = 3'd3;
				shamt = 3'd3;
			end
			8'd16: begin
				code  = 3'd4;
				shamt = 3'd4;
			end
			8'd32: begin
				code  = 3'd7;
				shamt = 3'd5;
			end
			default: begin
				ms_ok = 1'b0;
			end
		endcase
	end

	assign floor_v = cfg.min_delay_full >> shamt;

	always_comb begin
		if (!mode) begin
			cmd.kind = dspg_pkg::KIND_TICK;
		end else if (enable_cmd == 8'd0) begin
			cmd.kind = dspg_pkg::KIND_OFF;
		end else if (!ms_ok) begin
			cmd.kind = dspg_pkg::KIND_BADMS;
		end else begin
			cmd.kind = dspg_pkg::KIND_RUN;
		end
		cmd.ms_code = code;
		cmd.dir_l   = (dir_left_cmd == 8'd1);
		cmd.dir_r   = (dir_right_cmd == 8'd1);
	end

	assign period_l = clamp(delay_left, floor_v, cfg.max_delay);
	assign period_r = clamp(delay_right, floor_v, cfg.max_delay);

endmodule

>>> rtl/core/dspg_queue.sv
`timescale 1ns / 1ps
// Short item queue between the front and back parts.
// Generic width and depth; no package dependency.
module dspg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/dspg_back.sv
`timescale 1ns / 1ps
// Back part: timers, watchdog, step toggling and the pin register.
// Depends on dspg_pkg for cmd_t and the kind codes.
module dspg_back #(
	parameter int TIMER_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  dspg_pkg::cmd_t                   cmd,
	input  logic [TIMER_WIDTH-1:0]           new_pl,
	input  logic [TIMER_WIDTH-1:0]           new_pr,
	input  logic [dspg_pkg::CFG_DATA_W-1:0]  watchdog_limit,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             enable_n,
	output logic [dspg_pkg::MS_CODE_W-1:0]   microstep_pins,
	output logic                             dir_left,
	output logic                             dir_right,
	output logic                             step_left,
	output logic                             step_right,
	output logic                             timed_out
);

	localparam int TW = TIMER_WIDTH;
	localparam int CW = (TW + 1 > dspg_pkg::CFG_DATA_W) ? TW + 1 : dspg_pkg::CFG_DATA_W;

	logic [TW-1:0] cc_q, tl_q, tr_q, pl_q, pr_q, idle_q;
	logic          en_n_q, dl_q, dr_q, sl_q, sr_q, to_q, ov_q;
	logic [dspg_pkg::MS_CODE_W-1:0] ms_q;

	logic [TW-1:0] now;
	logic [TW:0]   sum_full;
	logic [TW-1:0] sum_sat;
	logic [CW-1:0] lim_x;
	logic          trip, idle_le, fire_l, fire_r;

	assign pop = !q_empty && (!ov_q || !out_stall);

	assign now      = (cc_q == '1) ? cc_q : cc_q + 1'b1;
	assign sum_full = {1'b0, idle_q} + {1'b0, now};
	assign sum_sat  = sum_full[TW] ? '1 : sum_full[TW-1:0];
	assign lim_x    = CW'(watchdog_limit);
	assign trip     = sum_full[TW] || (CW'(sum_full) > lim_x);
	assign idle_le  = CW'(idle_q) <= lim_x;
	assign fire_l   = (pl_q != '0) && (now >= tl_q);
	assign fire_r   = (pr_q != '0) && (now >= tr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			to_q   <= 1'b0;
			cc_q   <= '0;
			tl_q   <= '0;
			tr_q   <= '0;
			pl_q   <= '0;
			pr_q   <= '0;
			idle_q <= '0;
			en_n_q <= 1'b1;
			ms_q   <= '0;
			dl_q   <= 1'b0;
			dr_q   <= 1'b0;
			sl_q   <= 1'b0;
			sr_q   <= 1'b0;
		end else begin
			if (pop) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			if (pop) begin
				to_q <= 1'b0;
				case (cmd.kind)
					dspg_pkg::KIND_TICK: begin
						if (trip) begin
							to_q   <= 1'b1;
							en_n_q <= 1'b1;
							cc_q   <= '0;
							if (idle_le) idle_q <= sum_sat;
						end else begin
							cc_q <= (fire_l || fire_r) ? '0 : now;
							if (fire_l || fire_r) idle_q <= sum_sat;
							if (fire_l) begin
								sl_q <= !sl_q;
								tl_q <= pl_q;
							end else if (fire_r) begin
								tl_q <= (tl_q > now) ? tl_q - now : '0;
							end
							if (fire_r) begin
								sr_q <= !sr_q;
								tr_q <= pr_q;
							end else if (fire_l) begin
								tr_q <= (tr_q > now) ? tr_q - now : '0;
							end
						end
					end
					dspg_pkg::KIND_OFF: begin
						en_n_q <= 1'b1;
					end
					dspg_pkg::KIND_BADMS: begin
						en_n_q <= 1'b0;
					end
					dspg_pkg::KIND_RUN: begin
						en_n_q <= 1'b0;
						ms_q   <= cmd.ms_code;
						dl_q   <= cmd.dir_l;
						dr_q   <= cmd.dir_r;
						idle_q <= '0;
						if (new_pl != pl_q || new_pr != pr_q) begin
							pl_q <= new_pl;
							pr_q <= new_pr;
							tl_q <= new_pl;
							tr_q <= new_pr;
							cc_q <= '0;
						end
					end
					default: begin
						en_n_q <= en_n_q;
					end
				endcase
			end
		end
	end

	assign out_valid      = ov_q;
	assign enable_n       = en_n_q;
	assign microstep_pins = ms_q;
	assign dir_left       = dl_q;
	assign dir_right      = dr_q;
	assign step_left      = sl_q;
	assign step_right     = sr_q;
	assign timed_out      = to_q;

endmodule

>>> rtl/core/dual_stepper_pulse_generator_unit.sv
`timescale 1ns / 1ps
// Top level of the dual stepper pulse generator: config registers, front, queue, back.
// Depends on dspg_pkg, dspg_front, dspg_queue and dspg_back.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | mode, enable_cmd, microstep, dir_*_cmd, delay_*
//  out     | out_valid/out_stall| enable_n, microstep_pins, dir_*, step_*, timed_out
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item is first written
// into the queue, then popped into the back part's timer update and the pin register.
// Reset clears the timers and pins, sets enable_n and loads the register defaults.
// in_stall rises only when the two-entry queue is full; out_stall holds the pin register while out_valid is high.
module dual_stepper_pulse_generator_unit #(
	parameter int TIMER_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [7:0]                       enable_cmd,
	input  logic [7:0]                       microstep,
	input  logic [7:0]                       dir_left_cmd,
	input  logic [7:0]                       dir_right_cmd,
	input  logic [dspg_pkg::DELAY_W-1:0]     delay_left,
	input  logic [dspg_pkg::DELAY_W-1:0]     delay_right,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             enable_n,
	output logic [dspg_pkg::MS_CODE_W-1:0]   microstep_pins,
	output logic                             dir_left,
	output logic                             dir_right,
	output logic                             step_left,
	output logic                             step_right,
	output logic                             timed_out,
	input  logic                             cfg_we,
	input  logic [dspg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dspg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CMD_W = $bits(dspg_pkg::cmd_t);
	localparam int QW    = CMD_W + 2 * TIMER_WIDTH;

	dspg_pkg::cfg_t         cfg_q;
	dspg_pkg::cmd_t         f_cmd, b_cmd;
	logic [TIMER_WIDTH-1:0] f_pl, f_pr, b_pl, b_pr;
	logic [QW-1:0]          q_wdata, q_rdata;
	logic                   q_full, q_empty, q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_delay_full <= dspg_pkg::MIN_DELAY_FULL_RST;
			cfg_q.max_delay      <= dspg_pkg::MAX_DELAY_RST;
			cfg_q.watchdog_limit <= dspg_pkg::WATCHDOG_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dspg_pkg::CFG_MIN_DELAY_FULL: cfg_q.min_delay_full <= cfg_data;
				dspg_pkg::CFG_MAX_DELAY:      cfg_q.max_delay      <= cfg_data;
				dspg_pkg::CFG_WATCHDOG_LIMIT: cfg_q.watchdog_limit <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	dspg_front #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_front (
		.mode          (mode),
		.enable_cmd    (enable_cmd),
		.microstep     (microstep),
		.dir_left_cmd  (dir_left_cmd),
		.dir_right_cmd (dir_right_cmd),
		.delay_left    (delay_left),
		.delay_right   (delay_right),
		.cfg           (cfg_q),
		.cmd           (f_cmd),
		.period_l      (f_pl),
		.period_r      (f_pr)
	);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_wdata  = {f_cmd, f_pl, f_pr};

	dspg_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign b_cmd = dspg_pkg::cmd_t'(q_rdata[QW-1:2*TIMER_WIDTH]);
	assign b_pl  = q_rdata[2*TIMER_WIDTH-1:TIMER_WIDTH];
	assign b_pr  = q_rdata[TIMER_WIDTH-1:0];

	dspg_back #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.cmd            (b_cmd),
		.new_pl         (b_pl),
		.new_pr         (b_pr),
		.watchdog_limit (cfg_q.watchdog_limit),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.enable_n       (enable_n),
		.microstep_pins (microstep_pins),
		.dir_left       (dir_left),
		.dir_right      (dir_right),
		.step_left      (step_left),
		.step_right     (step_right),
		.timed_out      (timed_out)
	);

endmodule

>>> tb/dual_stepper_pulse_generator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dual_stepper_pulse_generator_unit: frames and ticks go in through
// a queue-fed driver, each pin result is checked against an in-bench pin predictor.
// Depends on dspg_pkg and the RTL of the block only.
module dual_stepper_pulse_generator_unit_tb;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_FRAME = 1'b1;
	localparam logic [dspg_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

	typedef struct {
		logic        mode;
		logic [7:0]  enable_cmd;
		logic [7:0]  microstep;
		logic [7:0]  dir_l_cmd;
		logic [7:0]  dir_r_cmd;
		logic [31:0] delay_l;
		logic [31:0] delay_r;
		int          gap;
	} stim_t;

	typedef struct packed {
		logic       en_n;
		logic [2:0] ms;
		logic       dir_l;
		logic       dir_r;
		logic       step_l;
		logic       step_r;
		logic       timed_out;
	} pins_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [7:0] enable_cmd = '0;
	logic [7:0] microstep = '0;
	logic [7:0] dir_left_cmd = '0;
	logic [7:0] dir_right_cmd = '0;
	logic [dspg_pkg::DELAY_W-1:0] delay_left = '0;
	logic [dspg_pkg::DELAY_W-1:0] delay_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic enable_n;
	logic [dspg_pkg::MS_CODE_W-1:0] microstep_pins;
	logic dir_left;
	logic dir_right;
	logic step_left;
	logic step_right;
	logic timed_out;
	logic cfg_we = 1'b0;
	logic [dspg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dspg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	dual_stepper_pulse_generator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.enable_cmd(enable_cmd),
		.microstep(microstep),
		.dir_left_cmd(dir_left_cmd),
		.dir_right_cmd(dir_right_cmd),
		.delay_left(delay_left),
		.delay_right(delay_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.enable_n(enable_n),
		.microstep_pins(microstep_pins),
		.dir_left(dir_left),
		.dir_right(dir_right),
		.step_left(step_left),
		.step_right(step_right),
		.timed_out(timed_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	bit [31:0] min_full_cfg = dspg_pkg::MIN_DELAY_FULL_RST;
	bit [31:0] max_delay_cfg = dspg_pkg::MAX_DELAY_RST;
	bit [31:0] wd_limit_cfg = dspg_pkg::WATCHDOG_LIMIT_RST;
	bit [31:0] run_count = '0;
	bit [31:0] aim_left = '0;
	bit [31:0] aim_right = '0;
	bit [31:0] half_left = '0;
	bit [31:0] half_right = '0;
	bit [31:0] quiet_time = '0;
	bit pin_en_n = 1'b1;
	bit [2:0] pin_ms = '0;
	bit pin_dir_l = 1'b0;
	bit pin_dir_r = 1'b0;
	bit pin_step_l = 1'b0;
	bit pin_step_r = 1'b0;

	stim_t pending[$];
	pins_t pins_expected[$];
	stim_t cur_item;
	pins_t want;
	pins_t got;
	bit in_fire = 1'b0;
	int send_wait = 0;
	int stall_left = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int errors = 0;
	logic [31:0] last_delay_l = '0;
	logic [31:0] last_delay_r = '0;

	function automatic bit [32:0] add_sat(input bit [31:0] a, input bit [31:0] b);
		bit [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? {1'b1, 32'hFFFF_FFFF} : s;
	endfunction

	function automatic bit [31:0] clamp_half(input bit [31:0] d, input bit [31:0] floor_v);
		if (d != 0 && d < floor_v)
			d = floor_v;
		if (d > max_delay_cfg)
			d = max_delay_cfg;
		return d;
	endfunction

	function automatic pins_t predict_pins(input stim_t it);
		dspg_pkg::kind_t kind;
		bit [2:0] code;
		bit [32:0] sum;
		bit [31:0] now;
		bit [31:0] floor_v;
		bit [31:0] nl;
		bit [31:0] nr;
		bit tripped;
		code = 3'b000;
		tripped = 1'b0;
		kind = dspg_pkg::KIND_RUN;
		if (it.mode == MODE_TICK)
			kind = dspg_pkg::KIND_TICK;
		else if (it.enable_cmd == 8'd0)
			kind = dspg_pkg::KIND_OFF;
		else case (it.microstep)
			8'd1: code = 3'b000;
			8'd2: code = 3'b001;
			8'd4: code = 3'b010;
			8'd8: code = 3'b011;
			8'd16: code = 3'b100;
			8'd32: code = 3'b111;
			default: kind = dspg_pkg::KIND_BADMS;
		endcase
		case (kind)
			dspg_pkg::KIND_TICK: begin
				sum = add_sat(run_count, 32'd1);
				run_count = sum[31:0];
				now = run_count;
				sum = add_sat(quiet_time, now);
				if (sum[32] || sum[31:0] > wd_limit_cfg) begin
					pin_en_n = 1'b1;
					if (quiet_time <= wd_limit_cfg)
						quiet_time = sum[31:0];
					run_count = '0;
					tripped = 1'b1;
				end else begin
					if (half_left != 0 && now >= aim_left) begin
						pin_step_l = ~pin_step_l;
						sum = add_sat(quiet_time, now);
						quiet_time = sum[31:0];
						aim_right = (aim_right > now) ? aim_right - now : '0;
						aim_left = half_left;
						run_count = '0;
						now = '0;
					end
					if (half_right != 0 && now >= aim_right) begin
						pin_step_r = ~pin_step_r;
						sum = add_sat(quiet_time, now);
						quiet_time = sum[31:0];
						aim_left = (aim_left > now) ? aim_left - now : '0;
						aim_right = half_right;
						run_count = '0;
					end
				end
			end
			dspg_pkg::KIND_OFF: pin_en_n = 1'b1;
			dspg_pkg::KIND_BADMS: pin_en_n = 1'b0;
			dspg_pkg::KIND_RUN: begin
				pin_en_n = 1'b0;
				pin_ms = code;
				pin_dir_l = (it.dir_l_cmd == 8'd1);
				pin_dir_r = (it.dir_r_cmd == 8'd1);
				floor_v = min_full_cfg / {24'd0, it.microstep};
				nl = clamp_half(it.delay_l, floor_v);
				nr = clamp_half(it.delay_r, floor_v);
				if (nl != half_left || nr != half_right) begin
					half_left = nl;
					half_right = nr;
					aim_left = nl;
					aim_right = nr;
					run_count = '0;
				end
				quiet_time = '0;
			end
		endcase
		return {pin_en_n, pin_ms, pin_dir_l, pin_dir_r, pin_step_l, pin_step_r, tripped};
	endfunction

	task automatic flag_result(input string what, input pins_t exp_v, input pins_t act_v);
		errors++;
		if (errors <= 10) begin
			$display("%0t %s: expected en_n=%b ms=%b dir=%b%b step=%b%b to=%b", $time, what,
				exp_v.en_n, exp_v.ms, exp_v.dir_l, exp_v.dir_r, exp_v.step_l, exp_v.step_r,
				exp_v.timed_out);
			$display("%0t %s: actual   en_n=%b ms=%b dir=%b%b step=%b%b to=%b", $time, what,
				act_v.en_n, act_v.ms, act_v.dir_l, act_v.dir_r, act_v.step_l, act_v.step_r,
				act_v.timed_out);
		end
	endtask

	// drive the next item at the falling edge, hold a stalled one
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pending.size() != 0 && send_wait < pending[0].gap) begin
				send_wait++;
				in_valid <= 1'b0;
			end else if (pending.size() != 0 && arst_n) begin
				cur_item = pending.pop_front();
				send_wait = 0;
				in_valid <= 1'b1;
				mode <= cur_item.mode;
				enable_cmd <= cur_item.enable_cmd;
				microstep <= cur_item.microstep;
				dir_left_cmd <= cur_item.dir_l_cmd;
				dir_right_cmd <= cur_item.dir_r_cmd;
				delay_left <= cur_item.delay_l;
				delay_right <= cur_item.delay_r;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire)
			pins_expected.push_back(predict_pins(cur_item));
		if (arst_n && out_valid && !out_stall) begin
			got = {enable_n, microstep_pins, dir_left, dir_right, step_left, step_right,
				timed_out};
			if ($urandom_range(0, 63) == 0)
				recv_calm = ~recv_calm;
			stall_left = recv_calm ? 0 : $urandom_range(0, 15);
			if (pins_expected.size() == 0) begin
				flag_result("unexpected item", got, got);
			end else begin
				want = pins_expected.pop_front();
				if (got.en_n !== want.en_n || got.ms !== want.ms
						|| got.dir_l !== want.dir_l || got.dir_r !== want.dir_r
						|| got.step_l !== want.step_l || got.step_r !== want.step_r
						|| got.timed_out !== want.timed_out)
					flag_result("mismatch", want, got);
			end
		end
	end

	task automatic push_item(input stim_t it);
		if ($urandom_range(0, 49) == 0)
			send_calm = ~send_calm;
		it.gap = send_calm ? 0 : $urandom_range(0, 15);
		pending.push_back(it);
	endtask

	task automatic queue_tick;
		stim_t it;
		it = '{MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0, 0};
		push_item(it);
	endtask

	task automatic queue_frame(input logic [7:0] en, input logic [7:0] ms,
			input logic [7:0] dl, input logic [7:0] dr,
			input logic [31:0] delay_l, input logic [31:0] delay_r);
		stim_t it;
		it = '{MODE_FRAME, en, ms, dl, dr, delay_l, delay_r, 0};
		last_delay_l = delay_l;
		last_delay_r = delay_r;
		push_item(it);
	endtask

	task automatic queue_random_item(input int frame_pct, input int delay_top);
		logic [7:0] en;
		logic [7:0] ms;
		logic [7:0] dl;
		logic [7:0] dr;
		logic [31:0] d_l;
		logic [31:0] d_r;
		int pick;
		if ($urandom_range(0, 99) >= frame_pct) begin
			queue_tick();
		end else begin
			if ($urandom_range(0, 9) == 0)
				en = 8'd0;
			else
				en = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd1;
			if ($urandom_range(0, 9) == 0)
				ms = 8'($urandom_range(0, 255));
			else
				ms = 8'd1 << $urandom_range(0, 5);
			dl = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
			dr = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				d_l = $urandom;
				d_r = $urandom;
			end else if (pick < 4) begin
				d_l = last_delay_l;
				d_r = last_delay_r;
			end else begin
				d_l = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, delay_top);
				d_r = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, delay_top);
			end
			queue_frame(en, ms, dl, dr, d_l, d_r);
		end
	endtask

	task automatic write_reg(input logic [dspg_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			dspg_pkg::CFG_MIN_DELAY_FULL: min_full_cfg = val;
			dspg_pkg::CFG_MAX_DELAY: max_delay_cfg = val;
			dspg_pkg::CFG_WATCHDOG_LIMIT: wd_limit_cfg = val;
			default: ;
		endcase
	endtask

	// hold until every item has come back, then let the pipeline settle
	task automatic wait_idle;
		do begin
			@(posedge clk);
			#1;
		end while (pending.size() != 0 || in_valid || pins_expected.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		bit [31:0] min_v;
		bit [31:0] max_v;
		bit [31:0] wd_v;
		int frame_pct;
		int delay_top;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		queue_tick();
		queue_frame(8'd0, 8'd1, 8'd1, 8'd1, 32'd100, 32'd100);
		queue_frame(8'hFF, 8'd3, 8'd1, 8'd1, 32'd100, 32'd100);
		queue_frame(8'd1, 8'd1, 8'd1, 8'd0, 32'd1, 32'd0);
		queue_frame(8'h80, 8'd2, 8'd2, 8'd1, 32'hFFFF_FFFF, 32'd5);
		queue_tick();
		queue_frame(8'd1, 8'd4, 8'hFF, 8'hFF, 32'd0, 32'd0);
		queue_frame(8'd1, 8'd8, 8'd0, 8'd1, 32'h8000_0000, 32'd37500);
		queue_frame(8'd1, 8'd8, 8'd0, 8'd1, 32'h8000_0000, 32'd37500);
		queue_tick();
		queue_frame(8'd1, 8'd16, 8'd1, 8'd0, 32'd18750, 32'd200000001);
		queue_frame(8'd1, 8'd32, 8'd0, 8'd0, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_frame(8'd1, 8'd0, 8'd1, 8'd1, 32'd1, 32'd1);
		queue_frame(8'd1, 8'hFF, 8'd1, 8'd1, 32'd1, 32'd1);
		queue_frame(8'd1, 8'd64, 8'd1, 8'd1, 32'd1, 32'd1);
		queue_frame(8'h01, 8'd32, 8'd1, 8'd1, 32'd9375, 32'd9374);
		queue_frame(8'd0, 8'd32, 8'd0, 8'd0, 32'd0, 32'd0);
		queue_tick();
		queue_tick();
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin min_v = 40; max_v = 30; wd_v = 150; frame_pct = 6; delay_top = 40; end
				1: begin min_v = 0; max_v = 20; wd_v = 400; frame_pct = 3; delay_top = 24; end
				2: begin min_v = 320; max_v = 64; wd_v = 100; frame_pct = 8; delay_top = 80; end
				3: begin
					min_v = 100;
					max_v = 32'hFFFF_FFFF;
					wd_v = 32'hFFFF_FFFF;
					frame_pct = 10;
					delay_top = 60;
				end
				4: begin
					min_v = 32'hFFFF_FFFF;
					max_v = 12;
					wd_v = 60;
					frame_pct = 4;
					delay_top = 20;
				end
				5: begin min_v = 5; max_v = 0; wd_v = 80; frame_pct = 5; delay_top = 30; end
				6: begin min_v = 16; max_v = 25; wd_v = 0; frame_pct = 15; delay_top = 30; end
				default: begin
					min_v = $urandom_range(0, 200);
					max_v = $urandom_range(1, 50);
					wd_v = $urandom_range(20, 500);
					frame_pct = $urandom_range(2, 15);
					delay_top = 50;
					write_reg(CFG_IDX_NONE, $urandom);
				end
			endcase
			write_reg(dspg_pkg::CFG_MIN_DELAY_FULL, min_v);
			write_reg(dspg_pkg::CFG_MAX_DELAY, max_v);
			write_reg(dspg_pkg::CFG_WATCHDOG_LIMIT, wd_v);
			for (int n = 0; n < 200; n++)
				queue_random_item(frame_pct, delay_top);
			wait_idle();
		end

		if (errors == 0 && pins_expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> dual_stepper_pulse_generator_unit.f
rtl/core/dspg_pkg.sv
rtl/core/dspg_front.sv
rtl/core/dspg_queue.sv
rtl/core/dspg_back.sv
rtl/core/dual_stepper_pulse_generator_unit.sv
tb/dual_stepper_pulse_generator_unit_tb.sv
